### rtl/sha256_pkg.sv
// SHA-256 package: initial hash values, round constants and round functions.
// No dependencies; used by the sha256_message_digest top level.
`timescale 1ns / 1ps
package sha256_pkg;

   typedef logic [31:0] word_type;

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LEN_FIELD_START = 6'd56;

   function automatic word_type init_chain(input logic [2:0] idx);
      word_type v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type ror32(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

endpackage

### rtl/sha256_message_digest.sv
// SHA-256 digest engine: byte packing, padding, block memory and round loop.
// Depends on sha256_pkg for constants and round functions.
`timescale 1ns / 1ps
//
// Usage:
// The req_ channel takes one transaction per message byte: req_msg_byte with
// req_has_byte set. req_end_of_message marks the last transaction; it may carry
// a byte or none (has_byte low, used for the empty message). A transaction with
// neither flag changes nothing. After the last transaction the block pads the
// message, compresses the remaining block or two and then presents eight rsp_
// transactions, digest words 0..7, rsp_final_word high on word 7.
// Sequence: each byte is a buffer read-modify-write, and no new transaction is
// taken until it is done. Every 64th byte starts a compression: the block is
// copied into the schedule memory, then 64 rounds run, each round bound by the
// schedule memory (read W[r-15] and W[r-2], then W[r-16] and W[r-7], then
// write W[r]), and last the variables fold into the hash. Padding writes its
// bytes by the same read-modify-write. The digest words leave at one per cycle
// while rsp_ready is high; a stalled receiver holds the current word and the
// block takes no new transaction until all eight have gone.
// Reset (synchronous, active high) restores the initial hash values, clears
// the byte and length counters and drops rsp_valid; no clearing pass runs.
//
module sha256_message_digest (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_msg_byte,
   input  logic                   req_has_byte,
   input  logic                   req_end_of_message,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sha256_pkg::word_type   rsp_digest_word,
   output logic [2:0]             rsp_word_index,
   output logic                   rsp_final_word
);
   import sha256_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BYTE   = 4'd1;
   localparam logic [3:0] S_CINIT  = 4'd2;
   localparam logic [3:0] S_RA     = 4'd3;
   localparam logic [3:0] S_RB     = 4'd4;
   localparam logic [3:0] S_RC     = 4'd5;
   localparam logic [3:0] S_FOLD   = 4'd6;
   localparam logic [3:0] S_PAD    = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   // Padding phases: marker pending, zero fill, length field.
   localparam logic [1:0] P_MARK   = 2'd0;
   localparam logic [1:0] P_FILL   = 2'd1;
   localparam logic [1:0] P_LEN    = 2'd2;

   // Block memory: 16 words, one write and one registered read port each.
   word_type blk_mem [16];
   // Schedule memory: two banks hold identical copies for two reads a cycle.
   word_type sch_mem_a [16];
   word_type sch_mem_b [16];

   logic [3:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] padlen_ff, padlen_in;
   logic        padding_ff, padding_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  byte_ff, byte_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  widx_ff, widx_in;
   word_type    hash_ff [8];
   word_type    hash_in [8];
   word_type    var_ff [8];
   word_type    var_in [8];
   word_type    xa_ff, xa_in, xb_ff, xb_in;

   // Memory port controls.
   logic [3:0] blk_raddr, blk_waddr, sa_raddr, sb_raddr, s_waddr;
   logic       blk_we, s_we;
   word_type   blk_wdata, s_wdata;
   word_type   blk_rd_ff, sa_rd_ff, sb_rd_ff;

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_waddr] <= blk_wdata;
      end
      blk_rd_ff <= blk_mem[blk_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sch_mem_a[s_waddr] <= s_wdata;
         sch_mem_b[s_waddr] <= s_wdata;
      end
      sa_rd_ff <= sch_mem_a[sa_raddr];
      sb_rd_ff <= sch_mem_b[sb_raddr];
   end

   // Byte lane merge into the word read from the block memory.
   word_type merged;
   logic [1:0] lane;
   always_comb begin
      lane = pos_ff[1:0];
      merged = blk_rd_ff;
      case (lane)
         2'd0: merged[31:24] = byte_ff;
         2'd1: merged[23:16] = byte_ff;
         2'd2: merged[15:8]  = byte_ff;
         default: merged[7:0] = byte_ff;
      endcase
   end

   // Round arithmetic from the working variables and the current schedule word.
   logic [3:0] r4;
   word_type w_r, t1, t2;
   always_comb begin
      r4 = round_ff[3:0];
      if (round_ff < 7'd16) begin
         w_r = sa_rd_ff;
      end else begin
         w_r = sa_rd_ff + xa_ff + sb_rd_ff + xb_ff;
      end
      t1 = var_ff[7] + bsig1(var_ff[4]) + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
           + ROUND_K[round_ff[5:0]] + w_r;
      t2 = bsig0(var_ff[0])
           + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   // Main sequencer.
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      padlen_in  = padlen_ff;
      padding_in = padding_ff;
      phase_in   = phase_ff;
      byte_in    = byte_ff;
      round_in   = round_ff;
      widx_in    = widx_ff;
      hash_in    = hash_ff;
      var_in     = var_ff;
      xa_in      = xa_ff;
      xb_in      = xb_ff;
      blk_raddr  = pos_ff[5:2];
      blk_waddr  = pos_ff[5:2];
      blk_we     = 1'b0;
      blk_wdata  = merged;
      sa_raddr   = r4;
      sb_raddr   = r4;
      s_waddr    = r4;
      s_we       = 1'b0;
      s_wdata    = w_r;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_has_byte) begin
                  byte_in    = req_msg_byte;
                  len_in     = len_ff + 64'd8;
                  padlen_in  = len_ff + 64'd8;
                  padding_in = req_end_of_message;
                  phase_in   = P_MARK;
                  state_in   = S_BYTE;
               end else if (req_end_of_message) begin
                  padlen_in  = len_ff;
                  padding_in = 1'b1;
                  phase_in   = P_MARK;
                  state_in   = S_PAD;
               end
            end
         end
         // Read already issued; write the merged word back.
         S_BYTE: begin
            blk_we = 1'b1;
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'd63) begin
               round_in = 7'd0;
               state_in = S_CINIT;
            end else begin
               state_in = padding_ff ? S_PAD : S_IDLE;
            end
         end
         // Copy block into the schedule memory, one word a cycle, load variables.
         S_CINIT: begin
            blk_raddr = round_ff[3:0];
            if (round_ff != 7'd0) begin
               s_we    = 1'b1;
               s_waddr = 4'(round_ff - 7'd1);
               s_wdata = blk_rd_ff;
            end
            round_in = round_ff + 7'd1;
            if (round_ff == 7'd16) begin
               var_in   = hash_ff;
               round_in = 7'd0;
               state_in = S_RA;
            end
         end
         // Read W[r-15] and W[r-2].
         S_RA: begin
            sa_raddr = 4'(round_ff - 7'd15);
            sb_raddr = 4'(round_ff - 7'd2);
            state_in = S_RB;
         end
         // Read W[r-16] and W[r-7]; hold sigma terms.
         S_RB: begin
            xa_in    = sig0(sa_rd_ff);
            xb_in    = sig1(sb_rd_ff);
            sa_raddr = r4;
            sb_raddr = 4'(round_ff - 7'd7);
            state_in = S_RC;
         end
         // Round update and schedule write-back.
         S_RC: begin
            if (round_ff >= 7'd16) begin
               s_we = 1'b1;
            end
            for (int i = 7; i > 0; i--) begin
               var_in[i] = var_ff[i-1];
            end
            var_in[4] = var_ff[3] + t1;
            var_in[0] = t1 + t2;
            round_in  = round_ff + 7'd1;
            state_in  = (round_ff == 7'd63) ? S_FOLD : S_RA;
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + var_ff[i];
            end
            state_in = padding_ff ? S_PAD : S_IDLE;
         end
         // Choose the next pad byte while the read of its word is issued.
         S_PAD: begin
            state_in = S_BYTE;
            byte_in  = 8'd0;
            case (phase_ff)
               P_MARK: begin
                  byte_in  = PAD_MARKER;
                  phase_in = P_FILL;
               end
               P_FILL: begin
                  // Zero fill ends where the length field starts.
                  if (pos_ff == LEN_FIELD_START) begin
                     byte_in   = padlen_ff[63:56];
                     padlen_in = {padlen_ff[55:0], 8'd0};
                     phase_in  = P_LEN;
                  end
               end
               default: begin
                  // The last length byte closed the block: the digest is ready.
                  if (pos_ff == 6'd0) begin
                     widx_in  = 3'd0;
                     state_in = S_OUT;
                  end else begin
                     byte_in   = padlen_ff[63:56];
                     padlen_in = {padlen_ff[55:0], 8'd0};
                  end
               end
            endcase
         end
         S_OUT: begin
            if (rsp_ready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     hash_in[i] = init_chain(3'(i));
                  end
                  len_in     = 64'd0;
                  pos_in     = 6'd0;
                  padding_in = 1'b0;
                  widx_in    = 3'd0;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = hash_ff[widx_ff];
   assign rsp_word_index  = widx_ff;
   assign rsp_final_word  = (widx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_ff     <= 6'd0;
         len_ff     <= 64'd0;
         padding_ff <= 1'b0;
         phase_ff   <= P_MARK;
         widx_ff    <= 3'd0;
         round_ff   <= 7'd0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= init_chain(3'(i));
         end
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         padding_ff <= padding_in;
         phase_ff   <= phase_in;
         widx_ff    <= widx_in;
         round_ff   <= round_in;
         hash_ff    <= hash_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      padlen_ff <= padlen_in;
      byte_ff   <= byte_in;
      var_ff    <= var_in;
      xa_ff     <= xa_in;
      xb_ff     <= xb_in;
   end

endmodule
